FILE: rtl/dmx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMX512 slot receiver package
// Shared payload types, function codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package dmx_pkg;

   // Storage and field widths
   localparam int SLOT_DEPTH_DEFAULT = 512;
   localparam int COUNT_W            = 10;
   localparam int MS_W               = 17;
   localparam int TIMEOUT_W          = 16;
   localparam int BYTE_W             = 8;
   localparam int WORD_W             = 9;
   localparam int CSR_INDEX_W        = 1;
   localparam int CSR_DATA_W         = 16;

   // Register reset values
   localparam logic [COUNT_W-1:0]   MAX_SLOTS_RESET  = COUNT_W'(512);
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET    = TIMEOUT_W'(5000);

   // Item function codes
   typedef enum logic [1:0] {
      FUNC_WORD = 2'd0,
      FUNC_READ = 2'd1,
      FUNC_TICK = 2'd2
   } func_type;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_SLOTS = 1'b0,
      CSR_TIMEOUT   = 1'b1
   } csr_index_type;

   // Input item
   typedef struct packed {
      logic [1:0]         func;
      logic [WORD_W-1:0]  rx_word;
      logic [COUNT_W-1:0] channel;
   } req_type;

   // Result item
   typedef struct packed {
      logic [BYTE_W-1:0]  slot_value;
      logic               online;
      logic [1:0]         frame_state;
      logic [COUNT_W-1:0] slots_received;
   } rsp_type;

endpackage

FILE: rtl/dmx_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dmx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/dmx512_slot_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMX512 slot receiver
// Frames received UART words into slots, serves channel reads and tracks
// line activity against a millisecond timeout.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while req_stall is low. Its result
// passes through the registered read of the slot RAM and then the output
// register, which lets a new item in while a result waits.
// Slots live in a single RAM with one write and one read port. The RAM needs
// no clearing pass after reset: slots are always written in ascending order
// from slot 0, so a fill mark records how far the RAM has ever been written,
// and a read of a slot at or beyond the mark returns zero. Frame state, slot
// count and the millisecond counter are updated in the transfer cycle, so
// back-to-back items always see the state left by the item before them.
// Configuration is taken at any time; write it while the block is idle.
// ----------------------------------------------------------------------------
module dmx512_slot_receiver #(
   parameter int SLOT_DEPTH = dmx_pkg::SLOT_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input items
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dmx_pkg::req_type                    req_data,
   // Results
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dmx_pkg::rsp_type                    rsp_data,
   // Configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dmx_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dmx_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int ADDR_W = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
   localparam logic [dmx_pkg::COUNT_W-1:0] DEPTH_CNT = dmx_pkg::COUNT_W'(SLOT_DEPTH);
   localparam logic [dmx_pkg::MS_W-1:0]    MS_MAX    = '1;

   typedef enum logic [1:0] {
      ST_WAIT  = 2'd0,
      ST_START = 2'd1,
      ST_SLOTS = 2'd2
   } rx_state_type;

   // Configuration registers
   logic [dmx_pkg::COUNT_W-1:0]   max_slots_ff;
   logic [dmx_pkg::TIMEOUT_W-1:0] timeout_ff;

   // Frame state
   rx_state_type                  rx_state_ff,  rx_state_in;
   logic [dmx_pkg::COUNT_W-1:0]   slot_count_ff, slot_count_in;
   logic [dmx_pkg::COUNT_W-1:0]   fill_ff,      fill_in;
   logic [dmx_pkg::MS_W-1:0]      ms_ff,        ms_in;

   // Read stage and output stage
   logic                          s1_valid_ff;
   logic                          s1_hit_ff,    s1_hit_in;
   dmx_pkg::rsp_type              s1_data_ff,   s1_data_in;
   logic                          rsp_valid_ff;
   dmx_pkg::rsp_type              rsp_data_ff,  rsp_data_in;

   logic                          req_xfer;
   logic                          s1_move;
   logic                          is_read;
   logic                          capture_ok;
   logic                          wr_en;
   logic [dmx_pkg::COUNT_W-1:0]   ch_minus_one;
   logic [ADDR_W-1:0]             rd_addr;
   logic [ADDR_W-1:0]             wr_addr;
   logic [dmx_pkg::BYTE_W-1:0]    rd_data;

   // Handshakes
   assign s1_move   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_move;
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign is_read = (req_data.func == dmx_pkg::FUNC_READ);

   // Decide slot capture and frame transitions
   assign capture_ok = (slot_count_ff < max_slots_ff) && (slot_count_ff < DEPTH_CNT);

   always_comb begin
      rx_state_in   = rx_state_ff;
      slot_count_in = slot_count_ff;
      fill_in       = fill_ff;
      ms_in         = ms_ff;
      wr_en         = 1'b0;
      if (req_xfer) begin
         unique case (req_data.func)
            dmx_pkg::FUNC_WORD: begin
               if (!req_data.rx_word[8]) begin
                  rx_state_in   = ST_START;
                  slot_count_in = '0;
                  ms_in         = '0;
               end else begin
                  unique case (rx_state_ff)
                     ST_START: begin
                        rx_state_in = (req_data.rx_word[7:0] == '0) ? ST_SLOTS : ST_WAIT;
                     end
                     ST_SLOTS: begin
                        if (capture_ok) begin
                           wr_en         = 1'b1;
                           slot_count_in = slot_count_ff + 1'b1;
                           if (slot_count_ff == fill_ff) begin
                              fill_in = fill_ff + 1'b1;
                           end
                        end else begin
                           rx_state_in = ST_WAIT;
                        end
                     end
                     default: begin
                        rx_state_in = rx_state_ff;
                     end
                  endcase
               end
            end
            dmx_pkg::FUNC_TICK: begin
               if (ms_ff != MS_MAX) begin
                  ms_in = ms_ff + 1'b1;
               end
            end
            default: begin
               ms_in = ms_ff;
            end
         endcase
      end
   end

   // Address the slot RAM
   assign ch_minus_one = req_data.channel - 1'b1;
   assign rd_addr      = ch_minus_one[ADDR_W-1:0];
   assign wr_addr      = slot_count_ff[ADDR_W-1:0];

   dmx_ram #(
      .WIDTH (dmx_pkg::BYTE_W),
      .DEPTH (SLOT_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.rx_word[7:0]),
      .rd_en   (req_xfer && is_read),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Build the status part of the result from the state after the item
   always_comb begin
      s1_hit_in = is_read
               && (req_data.channel != '0)
               && (req_data.channel <= DEPTH_CNT)
               && (req_data.channel <= max_slots_ff)
               && (req_data.channel <= fill_ff);
      s1_data_in                = '0;
      s1_data_in.online         = (ms_in <= {1'b0, timeout_ff});
      s1_data_in.frame_state    = rx_state_in;
      s1_data_in.slots_received = slot_count_in;
   end

   // Merge read data into the result
   always_comb begin
      rsp_data_in            = s1_data_ff;
      rsp_data_in.slot_value = s1_hit_ff ? rd_data : '0;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         max_slots_ff  <= dmx_pkg::MAX_SLOTS_RESET;
         timeout_ff    <= dmx_pkg::TIMEOUT_RESET;
         rx_state_ff   <= ST_WAIT;
         slot_count_ff <= '0;
         fill_ff       <= '0;
         ms_ff         <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               dmx_pkg::CSR_MAX_SLOTS: max_slots_ff <= csr_data[dmx_pkg::COUNT_W-1:0];
               dmx_pkg::CSR_TIMEOUT:   timeout_ff   <= csr_data[dmx_pkg::TIMEOUT_W-1:0];
               default:                timeout_ff   <= timeout_ff;
            endcase
         end
         rx_state_ff   <= rx_state_in;
         slot_count_ff <= slot_count_in;
         fill_ff       <= fill_in;
         ms_ff         <= ms_in;
         if (s1_move) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_hit_ff  <= s1_hit_in;
         s1_data_ff <= s1_data_in;
      end
      if (s1_move && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Fill mark never passes the RAM depth
   assert property (@(posedge clock) disable iff (reset) fill_ff <= DEPTH_CNT)
      else $error("fill mark beyond slot RAM depth");

   // Every captured slot lies below the fill mark
   assert property (@(posedge clock) disable iff (reset) slot_count_ff <= fill_ff)
      else $error("slot count ahead of fill mark");

   // Awaiting a start code means no slot captured yet
   assert property (@(posedge clock) disable iff (reset)
      rx_state_ff == ST_START |-> slot_count_ff == '0)
      else $error("slots counted before start code");

   // A RAM write always advances the slot count
   assert property (@(posedge clock) disable iff (reset)
      wr_en |=> slot_count_ff == $past(slot_count_ff) + 1'b1)
      else $error("slot write without count advance");

endmodule
